/* rtl/core/sliding_window_line_fit_core_defines.svh */
// Assertion macros shared by the sliding window line fit checkers
`ifndef SLIDING_WINDOW_LINE_FIT_CORE_DEFINES_SVH
`define SLIDING_WINDOW_LINE_FIT_CORE_DEFINES_SVH

// same-cycle implication
`define SWF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWF_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/swf_pkg.sv */
// Types, constants and codes of the sliding window line fit core
`timescale 1ns / 1ps
package swf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WINDOW_MAX  = 64;
    localparam int STEP_LIMIT  = 64;
    localparam int PTR_BITS    = $clog2(WINDOW_MAX);
    localparam int CFG_BITS    = 7;
    localparam int SX_BITS     = 22;
    localparam int SXX_BITS    = 37;
    localparam int SXY_BITS    = 38;
    localparam int MA_BITS     = 48;
    localparam int MB_BITS     = 24;
    localparam int MP_BITS     = 72;
    localparam int DEN_BITS    = 52;

    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd16;
    localparam logic [CFG_BITS-1:0] STEP_RESET   = 7'd8;

    typedef enum logic [0:0] {
        CFG_WINDOW_SIZE,
        CFG_STEP_SIZE
    } t_cfg_reg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] y;
        logic signed [SAMPLE_BITS-1:0] x;
        logic                          fin;
    } t_item;

    typedef struct packed {
        logic                      start;
        logic signed [MA_BITS-1:0] a;
        logic signed [MB_BITS-1:0] b;
    } t_mul_req;

    typedef enum logic [2:0] {
        OP_NSXX,
        OP_SXSX,
        OP_NSXY,
        OP_SXSY,
        OP_NXM,
        OP_DADIFF,
        OP_SYD,
        OP_ND
    } t_mul_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_RD_MID,
        ST_MID_CAP,
        ST_MUL,
        ST_MUL_WAIT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_EMIT_FIT,
        ST_EMIT_RAW
    } t_state;

endpackage

/* rtl/core/swf_ram.sv */
// Generic single write, single registered read RAM
`timescale 1ns / 1ps
module swf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/swf_front.sv */
// Input side: accepts sample items into a two-entry queue
`timescale 1ns / 1ps
module swf_front import swf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_item  i_item,
    output logic   o_q_valid,
    input  logic   i_q_ready,
    output t_item  o_q_item
);
    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rd];
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end
endmodule

/* rtl/core/swf_mul.sv */
// Bit-serial signed multiplier shared by the fit steps
`timescale 1ns / 1ps
module swf_mul import swf_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mul_req                  i_req,
    output logic                      o_done,
    output logic signed [MP_BITS-1:0] o_prod
);
    localparam int CNT_BITS = $clog2(MB_BITS);

    logic                r_busy;
    logic                r_fix;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [MP_BITS-1:0]  r_a;
    logic [MB_BITS-1:0]  r_b;
    logic [MP_BITS-1:0]  r_acc;
    logic                r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(MB_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= MP_BITS'(i_req.a[MA_BITS-1] ? MA_BITS'(-i_req.a) : MA_BITS'(i_req.a));
            r_b   <= i_req.b[MB_BITS-1] ? MB_BITS'(-i_req.b) : MB_BITS'(i_req.b);
            r_acc <= '0;
            r_neg <= i_req.a[MA_BITS-1] ^ i_req.b[MB_BITS-1];
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end else if (r_fix) begin
            if (r_neg) begin
                r_acc <= -r_acc;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = signed'(r_acc);
endmodule

/* rtl/core/swf_div.sv */
// Restoring divider: rounded, saturated quotient of the fit
`timescale 1ns / 1ps
module swf_div import swf_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [MP_BITS-1:0]     i_num,
    input  logic [DEN_BITS-1:0]           i_den,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_quot
);
    localparam int MD_BITS  = MP_BITS + 1;
    localparam int REM_BITS = DEN_BITS + 2;
    localparam int CNT_BITS = $clog2(MD_BITS);
    localparam int Q_BITS   = SAMPLE_BITS + 1;
    localparam logic [Q_BITS-1:0] POS_LIM = Q_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic [Q_BITS-1:0] NEG_LIM = Q_BITS'(1 << (SAMPLE_BITS - 1));

    logic                          r_prep;
    logic                          r_busy;
    logic                          r_fin;
    logic                          r_done;
    logic [CNT_BITS-1:0]           r_cnt;
    logic [MD_BITS-1:0]            r_m;
    logic [DEN_BITS-1:0]           r_den;
    logic [REM_BITS-1:0]           r_rem;
    logic [Q_BITS-1:0]             r_q;
    logic                          r_big;
    logic                          r_neg;
    logic signed [SAMPLE_BITS-1:0] r_quot;
    logic [REM_BITS-1:0]           rem_sh;
    logic [REM_BITS-1:0]           den2;
    logic                          ge;

    assign rem_sh = {r_rem[REM_BITS-2:0], r_m[MD_BITS-1]};
    assign den2   = REM_BITS'({r_den, 1'b0});
    assign ge     = (rem_sh >= den2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep <= 1'b0;
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_prep <= 1'b1;
            end else if (r_prep) begin
                r_prep <= 1'b0;
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(MD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m   <= MD_BITS'(i_num[MP_BITS-1] ? MP_BITS'(-i_num) : MP_BITS'(i_num));
            r_den <= i_den;
            r_neg <= i_num[MP_BITS-1];
        end else if (r_prep) begin
            r_m   <= (r_m << 1) + MD_BITS'(r_den);
            r_rem <= '0;
            r_q   <= '0;
            r_big <= 1'b0;
        end else if (r_busy) begin
            r_m   <= r_m << 1;
            r_rem <= ge ? rem_sh - den2 : rem_sh;
            r_q   <= {r_q[Q_BITS-2:0], ge};
            r_big <= r_big | r_q[Q_BITS-1];
        end else if (r_fin) begin
            if (r_neg) begin
                r_quot <= (r_big || r_q > NEG_LIM) ? SAMPLE_BITS'(-NEG_LIM)
                                                   : SAMPLE_BITS'(-r_q);
            end else begin
                r_quot <= (r_big || r_q > POS_LIM) ? SAMPLE_BITS'(POS_LIM)
                                                   : SAMPLE_BITS'(r_q);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

/* rtl/core/swf_back.sv */
// Back end: window store, running sums, fit sequencer and result register
`timescale 1ns / 1ps
module swf_back import swf_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [0:0]                    i_cfg_addr,
    input  logic [CFG_BITS-1:0]           i_cfg_wdata,
    input  logic                          i_q_valid,
    output logic                          o_q_ready,
    input  t_item                         i_q_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_x,
    output logic signed [SAMPLE_BITS-1:0] o_y,
    output logic                          o_raw,
    output logic                          o_last
);
    t_state                        r_state;
    t_state                        n_state;
    t_mul_op                       r_op;
    logic [CFG_BITS-1:0]           r_wsize;
    logic [CFG_BITS-1:0]           r_ssize;
    logic signed [SX_BITS-1:0]     r_sx;
    logic signed [SX_BITS-1:0]     r_sy;
    logic [SXX_BITS-1:0]           r_sxx;
    logic signed [SXY_BITS-1:0]    r_sxy;
    logic [CFG_BITS-1:0]           r_fill;
    logic [PTR_BITS-1:0]           r_phase;
    logic [PTR_BITS-1:0]           r_wp;
    t_item                         r_item;
    logic signed [SAMPLE_BITS-1:0] r_xm;
    logic signed [SAMPLE_BITS-1:0] r_fy;
    logic signed [MP_BITS-1:0]     r_t;
    logic signed [MA_BITS-1:0]     r_d;
    logic signed [MA_BITS-1:0]     r_da;
    logic signed [MB_BITS-1:0]     r_diff;
    logic signed [MP_BITS-1:0]     r_num;
    logic [DEN_BITS-1:0]           r_den;

    logic [CFG_BITS-1:0]           w_eff;
    logic [CFG_BITS-1:0]           s_eff;
    logic                          full;
    logic [CFG_BITS-1:0]           fill_nx;
    logic                          at_window;
    logic                          fit_now;
    logic [PTR_BITS-1:0]           old_addr;
    logic [PTR_BITS-1:0]           mid_addr;
    logic                          ram_we;
    logic [PTR_BITS-1:0]           ram_raddr;
    logic [2*SAMPLE_BITS-1:0]      ram_rdata;
    logic signed [SAMPLE_BITS-1:0] ox;
    logic signed [SAMPLE_BITS-1:0] oy;
    logic signed [2*SAMPLE_BITS-1:0] p_xx;
    logic signed [2*SAMPLE_BITS-1:0] p_xy;
    logic signed [2*SAMPLE_BITS-1:0] p_oo;
    logic signed [2*SAMPLE_BITS-1:0] p_oxy;
    t_mul_req                      mul_req;
    logic                          mul_done;
    logic signed [MP_BITS-1:0]     mul_prod;
    logic                          div_start;
    logic                          div_done;
    logic signed [SAMPLE_BITS-1:0] div_quot;
    logic                          det_zero;
    logic signed [MB_BITS-1:0]     n_b;

    always_comb begin
        if (r_wsize < CFG_BITS'(2)) begin
            w_eff = CFG_BITS'(2);
        end else if (r_wsize > CFG_BITS'(WINDOW_MAX)) begin
            w_eff = CFG_BITS'(WINDOW_MAX);
        end else begin
            w_eff = r_wsize;
        end
        s_eff = (r_ssize > CFG_BITS'(STEP_LIMIT)) ? CFG_BITS'(STEP_LIMIT) : r_ssize;
    end

    assign full      = (r_fill >= w_eff);
    assign fill_nx   = full ? w_eff : r_fill + 1'b1;
    assign at_window = (fill_nx == w_eff) && (s_eff != '0);
    assign fit_now   = at_window && (r_phase == '0);
    assign old_addr  = r_wp - w_eff[PTR_BITS-1:0];
    assign mid_addr  = r_wp - w_eff[PTR_BITS-1:0] + PTR_BITS'(w_eff >> 1);
    assign ox        = signed'(ram_rdata[SAMPLE_BITS-1:0]);
    assign oy        = signed'(ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign p_xx      = r_item.x * r_item.x;
    assign p_xy      = r_item.x * r_item.y;
    assign p_oo      = ox * ox;
    assign p_oxy     = ox * oy;
    assign det_zero  = (r_t == mul_prod);
    assign n_b       = MB_BITS'(signed'({1'b0, w_eff}));

    swf_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata ({r_item.y, r_item.x}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    swf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    swf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (fit_now) begin
                    n_state = ST_RD_MID;
                end else if (r_item.fin) begin
                    n_state = ST_EMIT_RAW;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD_MID:  n_state = ST_MID_CAP;
            ST_MID_CAP: n_state = ST_MUL;
            ST_MUL:     n_state = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    if (r_op == OP_SXSX && det_zero) begin
                        n_state = r_item.fin ? ST_EMIT_RAW : ST_IDLE;
                    end else if (r_op == OP_ND) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_DIV: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = ST_EMIT_FIT;
                end
            end
            ST_EMIT_FIT: begin
                if (i_ready) begin
                    n_state = r_item.fin ? ST_EMIT_RAW : ST_IDLE;
                end
            end
            ST_EMIT_RAW: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_ready     = (r_state == ST_IDLE);
        ram_we        = (r_state == ST_UPDATE);
        ram_raddr     = (r_state == ST_RD_MID) ? mid_addr : old_addr;
        div_start     = (r_state == ST_DIV);
        mul_req.start = (r_state == ST_MUL);
        mul_req.a     = '0;
        mul_req.b     = n_b;
        unique case (r_op)
            OP_NSXX: begin
                mul_req.a = MA_BITS'(signed'({1'b0, r_sxx}));
            end
            OP_SXSX: begin
                mul_req.a = MA_BITS'(r_sx);
                mul_req.b = MB_BITS'(r_sx);
            end
            OP_NSXY: begin
                mul_req.a = MA_BITS'(r_sxy);
            end
            OP_SXSY: begin
                mul_req.a = MA_BITS'(r_sy);
                mul_req.b = MB_BITS'(r_sx);
            end
            OP_NXM: begin
                mul_req.a = MA_BITS'(r_xm);
            end
            OP_DADIFF: begin
                mul_req.a = r_da;
                mul_req.b = r_diff;
            end
            OP_SYD: begin
                mul_req.a = r_d;
                mul_req.b = MB_BITS'(r_sy);
            end
            OP_ND: begin
                mul_req.a = r_d;
            end
            default: mul_req.a = '0;
        endcase
        o_valid = (r_state == ST_EMIT_FIT) || (r_state == ST_EMIT_RAW);
        o_raw   = (r_state == ST_EMIT_RAW);
        o_last  = (r_state == ST_EMIT_RAW) || !r_item.fin;
        o_x     = (r_state == ST_EMIT_RAW) ? r_item.x : r_xm;
        o_y     = (r_state == ST_EMIT_RAW) ? r_item.y : r_fy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_NSXX;
            r_wsize <= WINDOW_RESET;
            r_ssize <= STEP_RESET;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_sxy   <= '0;
            r_fill  <= '0;
            r_phase <= '0;
            r_wp    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en || (r_state == ST_EMIT_RAW && i_ready)) begin
                r_sx    <= '0;
                r_sy    <= '0;
                r_sxx   <= '0;
                r_sxy   <= '0;
                r_fill  <= '0;
                r_phase <= '0;
                r_wp    <= '0;
            end else if (r_state == ST_UPDATE) begin
                r_sx   <= r_sx - (full ? SX_BITS'(ox) : '0) + SX_BITS'(r_item.x);
                r_sy   <= r_sy - (full ? SX_BITS'(oy) : '0) + SX_BITS'(r_item.y);
                r_sxx  <= r_sxx - (full ? SXX_BITS'(p_oo) : '0) + SXX_BITS'(p_xx);
                r_sxy  <= r_sxy - (full ? SXY_BITS'(p_oxy) : '0) + SXY_BITS'(p_xy);
                r_fill <= fill_nx;
                r_wp   <= r_wp + 1'b1;
                if (at_window) begin
                    r_phase <= (CFG_BITS'(r_phase) + 1'b1 >= s_eff) ? '0 : r_phase + 1'b1;
                end
            end
            if (i_cfg_wr_en) begin
                unique case (t_cfg_reg'(i_cfg_addr))
                    CFG_WINDOW_SIZE: r_wsize <= i_cfg_wdata;
                    CFG_STEP_SIZE:   r_ssize <= i_cfg_wdata;
                    default:         r_wsize <= r_wsize;
                endcase
            end
            if (r_state == ST_UPDATE) begin
                r_op <= OP_NSXX;
            end else if (r_state == ST_MUL_WAIT && mul_done && r_op != OP_ND) begin
                r_op <= t_mul_op'(r_op + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q_valid) begin
            r_item <= i_q_item;
        end
        if (r_state == ST_MID_CAP) begin
            r_xm <= ox;
        end
        if (div_done) begin
            r_fy <= div_quot;
        end
        if (r_state == ST_MUL_WAIT && mul_done) begin
            unique case (r_op)
                OP_NSXX:   r_t    <= mul_prod;
                OP_SXSX:   r_d    <= MA_BITS'(r_t - mul_prod);
                OP_NSXY:   r_t    <= mul_prod;
                OP_SXSY:   r_da   <= MA_BITS'(r_t - mul_prod);
                OP_NXM:    r_diff <= MB_BITS'(mul_prod - MP_BITS'(r_sx));
                OP_DADIFF: r_t    <= mul_prod;
                OP_SYD:    r_num  <= r_t + mul_prod;
                OP_ND:     r_den  <= mul_prod[DEN_BITS-1:0];
                default:   r_t    <= r_t;
            endcase
        end
    end
endmodule

/* rtl/core/sliding_window_line_fit_core.sv */
// Top level of the sliding window line fit core
`timescale 1ns / 1ps
// Fits a straight line to the last window_size (x,y) samples every step_size
// samples and emits the fitted y at the window's middle x; a sample marked
// with tlast also comes out raw, flagged in tuser, and ends the data set.
// Samples enter a two-entry queue and the back end handles one at a time:
// a sample that completes a fit is held while the fit runs eight passes
// through the bit-serial 48x24 multiplier and the 73-step restoring divider.
// A result holds on the output until taken. Configuration writes clear the
// window and the running sums.
module sliding_window_line_fit_core import swf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [0:0]             i_cfg_addr,
    input  logic [CFG_BITS-1:0]    i_cfg_wdata,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [2*SAMPLE_BITS-1:0] i_s_tdata,  // sample_x, sample_y
    input  logic                   i_s_tlast,    // final_sample
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [2*SAMPLE_BITS-1:0] o_m_tdata,  // point_x, point_y
    output logic [0:0]             o_m_tuser,    // raw_point
    output logic                   o_m_tlast     // run_end
);
    t_item                         in_item;
    t_item                         q_item;
    logic                          q_valid;
    logic                          q_ready;
    logic signed [SAMPLE_BITS-1:0] out_x;
    logic signed [SAMPLE_BITS-1:0] out_y;
    logic                          out_raw;

    assign in_item.x   = signed'(i_s_tdata[SAMPLE_BITS-1:0]);
    assign in_item.y   = signed'(i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign in_item.fin = i_s_tlast;

    swf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    swf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_item    (q_item),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_x         (out_x),
        .o_y         (out_y),
        .o_raw       (out_raw),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {out_y, out_x};
    assign o_m_tuser = out_raw;
endmodule

/* rtl/core/swf_checker.sv */
// Port-level checks of the sliding window line fit core
`timescale 1ns / 1ps
`include "sliding_window_line_fit_core_defines.svh"
module swf_checker import swf_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [2*SAMPLE_BITS-1:0] o_m_tdata,
    input logic [0:0]               o_m_tuser,
    input logic                     o_m_tlast
);
    `SWF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "stalled result changed")
    `SWF_ASSERT_IMP(a_raw_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tlast, "raw point not marked last")
    `SWF_ASSERT_NXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_m_tvalid, "result valid after reset")
endmodule

bind sliding_window_line_fit_core swf_checker u_swf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
